// File: hdl/ucl_pkg.sv
// Shared types, codes and command text tables for the command line matcher.
package ucl_pkg;

  typedef enum logic [3:0] {
    CODE_HELP      = 4'd0,
    CODE_LED_ON    = 4'd1,
    CODE_LED_OFF   = 4'd2,
    CODE_TOGGLE    = 4'd3,
    CODE_STATUS    = 4'd4,
    CODE_BAUD_QRY  = 4'd5,
    CODE_BAUD_OK   = 4'd6,
    CODE_BAUD_BAD  = 4'd7,
    CODE_UNKNOWN   = 4'd8,
    CODE_OVERFLOW  = 4'd9
  } cmd_code_e;

  typedef enum logic [1:0] {
    PH_BEFORE = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } num_phase_e;

  // Packed so that command_code sits in the lowest bits.
  typedef struct packed {
    logic        led_lit;
    logic [19:0] baud_value;
    cmd_code_e   command_code;
  } ucl_result_t;

  localparam int unsigned NUM_CMDS  = 7;
  localparam int unsigned NUM_START = 5;

  // Command indexes in priority order.
  localparam logic [2:0] CMD_HELP     = 3'd0;
  localparam logic [2:0] CMD_LAMP_ON  = 3'd1;
  localparam logic [2:0] CMD_LAMP_OFF = 3'd2;
  localparam logic [2:0] CMD_TOGGLE   = 3'd3;
  localparam logic [2:0] CMD_STATUS   = 3'd4;
  localparam logic [2:0] CMD_BAUD_QRY = 3'd5;
  localparam logic [2:0] CMD_BAUD_SET = 3'd6;
  localparam logic [2:0] CMD_NONE     = 3'd7;

  localparam logic [19:0] BAUD_SAT   = 20'd1048575;
  localparam logic [19:0] BAUD_LOW   = 20'd9600;
  localparam logic [19:0] BAUD_HIGH  = 20'd921600;
  localparam logic [19:0] BAUD_RESET = 20'd115200;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // String literals are right-justified: the last character is in the low byte.
  localparam logic [79:0] CMD_TEXT [NUM_CMDS] = '{
    80'("HELP"), 80'("LED ON"), 80'("LED OFF"), 80'("LED TOGGLE"),
    80'("STATUS"), 80'("BAUD?"), 80'("BAUD=")
  };

  localparam logic [3:0] CMD_LEN [NUM_CMDS] = '{
    4'd4, 4'd6, 4'd7, 4'd10, 4'd6, 4'd5, 4'd5
  };

  function automatic logic [7:0] cmd_char(input logic [2:0] k, input logic [3:0] pos);
    logic [79:0] text;
    logic [3:0]  idx;
    text = CMD_TEXT[k];
    idx  = CMD_LEN[k] - 4'd1 - pos;
    return text[{idx, 3'b000} +: 8];
  endfunction

endpackage

// File: hdl/uart_command_line_matcher_core.sv
// Top level of the command line matcher: stream ports, baud register, assertions.
//
// Takes one received byte per clock cycle, every cycle, for as long as the output side
// keeps up. A terminating CR or LF, or a byte that overflows the line, yields one result
// beat, registered into the output buffer; the line state (prefix flags, count and
// decimal accumulator) is updated in that same cycle. A two-entry output buffer lets
// the block keep taking bytes while one result waits to be taken; s_axis_tready_o drops
// only when both entries hold results. There is no clearing pass after reset. The user
// writes current_baud via cfg_we_i/cfg_wdata_i only while idle; the block has no check.
module uart_command_line_matcher_core #(
  parameter int unsigned LINE_MAX = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [19:0] cfg_wdata_i,     // current_baud
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o   // [3:0] command_code, [23:4] baud_value,
                                       // [24] led_lit, [31:25] zero
);

  logic [19:0]          current_baud_q;
  logic                 accept;
  logic                 res_valid;
  ucl_pkg::ucl_result_t res;
  ucl_pkg::ucl_result_t out_data;
  logic                 buf_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      current_baud_q <= ucl_pkg::BAUD_RESET;
    end else if (cfg_we_i) begin
      current_baud_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready_o = !buf_full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  ucl_line_parser #(
    .LINE_MAX(LINE_MAX)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .rx_byte_i      (s_axis_tdata_i),
    .current_baud_i (current_baud_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  ucl_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .ready_i     (m_axis_tready_i),
    .valid_o     (m_axis_tvalid_o),
    .data_o      (out_data),
    .full_o      (buf_full)
  );

  assign m_axis_tdata_o = {7'd0, out_data};

  // A full buffer always has a beat on offer, now and in the next cycle.
  a_full_has_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("output buffer full without a valid beat");

  a_full_keeps_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |=> m_axis_tvalid_o)
    else $error("beat lost after buffer was full");

  // Only baud commands carry a nonzero baud value.
  a_baud_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (out_data.command_code != ucl_pkg::CODE_BAUD_QRY)
      && (out_data.command_code != ucl_pkg::CODE_BAUD_OK)
      && (out_data.command_code != ucl_pkg::CODE_BAUD_BAD)
    |-> (out_data.baud_value == 20'd0))
    else $error("nonzero baud value on a non-baud result");

  a_led_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && ((out_data.command_code == ucl_pkg::CODE_LED_ON)
      || (out_data.command_code == ucl_pkg::CODE_LED_OFF))
    |-> (out_data.led_lit == (out_data.command_code == ucl_pkg::CODE_LED_ON)))
    else $error("LED state disagrees with LED command");

endmodule

// File: hdl/ucl_line_parser.sv
// Per-byte line state, prefix matching, number parsing and result decode.
module ucl_line_parser #(
  parameter int unsigned LINE_MAX = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           rx_byte_i,
  input  logic [19:0]          current_baud_i,
  output logic                 res_valid_o,
  output ucl_pkg::ucl_result_t res_o
);

  localparam int unsigned CNT_W = $clog2(LINE_MAX);

  logic                  receiving_q, receiving_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [6:0]            flags_q, flags_d;
  ucl_pkg::num_phase_e   phase_q, phase_d;
  logic                  neg_q, neg_d;
  logic [19:0]           accum_q, accum_d;
  logic                  lamp_q, lamp_d;

  logic                  is_eol, is_skip, is_digit, is_blank;
  logic [6:0]            flags_st;
  ucl_pkg::num_phase_e   phase_st;
  logic                  neg_st;
  logic [19:0]           accum_st;
  logic [23:0]           acc10;
  logic [6:0]            hit;
  logic [2:0]            sel;
  ucl_pkg::cmd_code_e    code;
  logic [19:0]           baud;

  always_comb begin
    is_eol   = (rx_byte_i == ucl_pkg::CH_CR) || (rx_byte_i == ucl_pkg::CH_LF);
    is_skip  = is_eol || (rx_byte_i == ucl_pkg::CH_SPACE) || (rx_byte_i == ucl_pkg::CH_TAB)
            || (rx_byte_i == ucl_pkg::CH_HASH) || (rx_byte_i == ucl_pkg::CH_SLASH);
    is_blank = (rx_byte_i == ucl_pkg::CH_SPACE) || (rx_byte_i == ucl_pkg::CH_TAB)
            || (rx_byte_i == ucl_pkg::CH_VT) || (rx_byte_i == ucl_pkg::CH_FF);
    is_digit = (rx_byte_i >= ucl_pkg::CH_ZERO) && (rx_byte_i <= ucl_pkg::CH_NINE);

    // A command drops out when a byte inside its text length differs.
    for (int k = 0; k < 7; k++) begin
      flags_st[k] = flags_q[k] &
                    !((count_q < CNT_W'(ucl_pkg::CMD_LEN[k])) &&
                      (rx_byte_i != ucl_pkg::cmd_char(3'(k), count_q[3:0])));
      hit[k] = flags_q[k] && (count_q >= CNT_W'(ucl_pkg::CMD_LEN[k]));
    end

    sel = ucl_pkg::CMD_NONE;
    for (int k = 6; k >= 0; k--) begin
      if (hit[k]) begin
        sel = 3'(k);
      end
    end

    // Multiply by ten as two shifts, then saturate.
    acc10 = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0} + {20'd0, rx_byte_i[3:0]};

    phase_st = phase_q;
    neg_st   = neg_q;
    accum_st = accum_q;
    if (count_q >= CNT_W'(ucl_pkg::NUM_START)) begin
      unique case (phase_q)
        ucl_pkg::PH_BEFORE: begin
          if (is_blank) begin
            phase_st = ucl_pkg::PH_BEFORE;
          end else if ((rx_byte_i == ucl_pkg::CH_PLUS) || (rx_byte_i == ucl_pkg::CH_MINUS)) begin
            neg_st   = (rx_byte_i == ucl_pkg::CH_MINUS);
            phase_st = ucl_pkg::PH_SIGN;
          end else if (is_digit) begin
            accum_st = {16'd0, rx_byte_i[3:0]};
            phase_st = ucl_pkg::PH_DIGITS;
          end else begin
            phase_st = ucl_pkg::PH_DONE;
          end
        end
        ucl_pkg::PH_SIGN: begin
          if (is_digit) begin
            accum_st = {16'd0, rx_byte_i[3:0]};
            phase_st = ucl_pkg::PH_DIGITS;
          end else begin
            phase_st = ucl_pkg::PH_DONE;
          end
        end
        ucl_pkg::PH_DIGITS: begin
          if (is_digit) begin
            accum_st = (acc10[23:20] != 4'd0) ? ucl_pkg::BAUD_SAT : acc10[19:0];
          end else begin
            phase_st = ucl_pkg::PH_DONE;
          end
        end
        ucl_pkg::PH_DONE: begin
          phase_st = ucl_pkg::PH_DONE;
        end
        default: begin
          phase_st = ucl_pkg::PH_DONE;
        end
      endcase
    end

    baud = 20'd0;
    unique case (sel)
      ucl_pkg::CMD_HELP:     code = ucl_pkg::CODE_HELP;
      ucl_pkg::CMD_LAMP_ON:  code = ucl_pkg::CODE_LED_ON;
      ucl_pkg::CMD_LAMP_OFF: code = ucl_pkg::CODE_LED_OFF;
      ucl_pkg::CMD_TOGGLE:   code = ucl_pkg::CODE_TOGGLE;
      ucl_pkg::CMD_STATUS:   code = ucl_pkg::CODE_STATUS;
      ucl_pkg::CMD_BAUD_QRY: begin
        code = ucl_pkg::CODE_BAUD_QRY;
        baud = current_baud_i;
      end
      ucl_pkg::CMD_BAUD_SET: begin
        // A negative value reports zero; minus zero is still zero.
        baud = neg_q ? 20'd0 : accum_q;
        code = (!neg_q && (accum_q >= ucl_pkg::BAUD_LOW) && (accum_q <= ucl_pkg::BAUD_HIGH))
             ? ucl_pkg::CODE_BAUD_OK : ucl_pkg::CODE_BAUD_BAD;
      end
      default: code = ucl_pkg::CODE_UNKNOWN;
    endcase

    receiving_d = receiving_q;
    count_d     = count_q;
    flags_d     = flags_q;
    phase_d     = phase_q;
    neg_d       = neg_q;
    accum_d     = accum_q;
    lamp_d      = lamp_q;
    res_valid_o = 1'b0;
    res_o.command_code = code;
    res_o.baud_value   = baud;
    res_o.led_lit      = lamp_q;

    if (accept_i) begin
      if (!receiving_q) begin
        if (!is_skip) begin
          receiving_d = 1'b1;
          flags_d     = flags_st;
          count_d     = count_q + 1'b1;
        end
      end else if (!is_eol && (count_q < CNT_W'(LINE_MAX - 1))) begin
        flags_d = flags_st;
        phase_d = phase_st;
        neg_d   = neg_st;
        accum_d = accum_st;
        count_d = count_q + 1'b1;
      end else begin
        res_valid_o = 1'b1;
        if (!is_eol) begin
          res_o.command_code = ucl_pkg::CODE_OVERFLOW;
          res_o.baud_value   = 20'd0;
        end else begin
          unique case (code)
            ucl_pkg::CODE_LED_ON:  lamp_d = 1'b1;
            ucl_pkg::CODE_LED_OFF: lamp_d = 1'b0;
            ucl_pkg::CODE_TOGGLE:  lamp_d = !lamp_q;
            default:               lamp_d = lamp_q;
          endcase
          res_o.led_lit = lamp_d;
        end
        receiving_d = 1'b0;
        count_d     = '0;
        flags_d     = '1;
        phase_d     = ucl_pkg::PH_BEFORE;
        neg_d       = 1'b0;
        accum_d     = 20'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q <= 1'b0;
      count_q     <= '0;
      flags_q     <= '1;
      phase_q     <= ucl_pkg::PH_BEFORE;
      neg_q       <= 1'b0;
      accum_q     <= 20'd0;
      lamp_q      <= 1'b0;
    end else begin
      receiving_q <= receiving_d;
      count_q     <= count_d;
      flags_q     <= flags_d;
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      accum_q     <= accum_d;
      lamp_q      <= lamp_d;
    end
  end

endmodule

// File: hdl/ucl_out_buf.sv
// Two-entry output buffer: a result register backed by one skid entry.
module ucl_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ucl_pkg::ucl_result_t push_data_i,
  input  logic                 ready_i,
  output logic                 valid_o,
  output ucl_pkg::ucl_result_t data_o,
  output logic                 full_o
);

  logic                 main_v_q, main_v_d;
  logic                 skid_v_q, skid_v_d;
  ucl_pkg::ucl_result_t main_q, main_d;
  ucl_pkg::ucl_result_t skid_q, skid_d;

  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    if (!main_v_q || ready_i) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        main_v_d = 1'b1;
        skid_d   = push_data_i;
        skid_v_d = push_i;
      end else begin
        main_d   = push_data_i;
        main_v_d = push_i;
      end
    end else if (push_i) begin
      // The skid entry is empty whenever a beat is pushed.
      skid_d   = push_data_i;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign valid_o = main_v_q;
  assign data_o  = main_q;
  assign full_o  = skid_v_q;

endmodule

// File: test/tb.sv
// Self-checking testbench for the command line matcher: byte stream in, command results out.
module tb;
  import ucl_pkg::*;

  localparam int LINE_LIMIT  = 64;
  localparam int QUIET_LIMIT = 5000;
  localparam int STALL_SPAN  = 400;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [19:0] cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;

  uart_command_line_matcher_core #(
    .LINE_MAX(LINE_LIMIT)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  string cmd_words [NUM_CMDS] = '{
    "HELP", "LED ON", "LED OFF", "LED TOGGLE", "STATUS", "BAUD?", "BAUD="
  };
  logic [7:0] idle_skips [6] = '{CH_SPACE, CH_TAB, CH_HASH, CH_SLASH, CH_CR, CH_LF};
  logic [7:0] num_blanks [4] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};
  logic [19:0] baud_edges [4] = '{BAUD_LOW, BAUD_HIGH, BAUD_LOW - 20'd1, BAUD_HIGH + 20'd1};

  // Predicted state of the matcher.
  bit          line_open;
  logic [7:0]  line_len;
  logic [6:0]  still_matching;
  num_phase_e  num_state;
  bit          num_neg;
  logic [19:0] num_mag;
  bit          led_state;
  logic [19:0] baud_reg;

  ucl_result_t awaited_commands [$];
  int          mismatch_count;
  int          fed_count;
  int          feed_idle_pct;
  int          sink_idle_pct;
  int          sink_hold_left;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("mismatch in %s at %0t: got %0d, expected %0d", what, $time, got, want);
    end
  endtask

  task automatic clear_line_state();
    line_open      = 1'b0;
    line_len       = '0;
    still_matching = '1;
    num_state      = PH_BEFORE;
    num_neg        = 1'b0;
    num_mag        = '0;
  endtask

  // Prefix tracking plus the atoi-like number scan from position five on.
  task automatic store_line_byte(input logic [7:0] b);
    int          pos;
    logic [31:0] grown;
    bit          is_digit;
    pos      = line_len;
    is_digit = (b >= CH_ZERO && b <= CH_NINE);
    for (int k = 0; k < NUM_CMDS; k++) begin
      if (pos < cmd_words[k].len() && b != cmd_words[k][pos]) still_matching[k] = 1'b0;
    end
    if (pos >= NUM_START) begin
      case (num_state)
        PH_BEFORE: begin
          if (!(b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF)) begin
            if (b == CH_PLUS || b == CH_MINUS) begin
              num_neg   = (b == CH_MINUS);
              num_state = PH_SIGN;
            end else if (is_digit) begin
              num_mag   = 20'(b - CH_ZERO);
              num_state = PH_DIGITS;
            end else begin
              num_state = PH_DONE;
            end
          end
        end
        PH_SIGN: begin
          if (is_digit) begin
            num_mag   = 20'(b - CH_ZERO);
            num_state = PH_DIGITS;
          end else begin
            num_state = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            grown   = 32'(num_mag) * 32'd10 + 32'(b - CH_ZERO);
            num_mag = (grown > 32'(BAUD_SAT)) ? BAUD_SAT : grown[19:0];
          end else begin
            num_state = PH_DONE;
          end
        end
        default: ;
      endcase
    end
    line_len = line_len + 8'd1;
  endtask

  // Advances the predicted state by one accepted byte and queues any result it causes.
  task automatic match_byte(input logic [7:0] b, output bit skipped);
    int          hit;
    ucl_result_t reply;
    skipped = 1'b0;
    if (!line_open) begin
      if (b == CH_SPACE || b == CH_TAB || b == CH_HASH || b == CH_SLASH ||
          b == CH_CR || b == CH_LF) begin
        skipped = 1'b1;
        return;
      end
      line_open = 1'b1;
      store_line_byte(b);
      return;
    end
    if (b != CH_CR && b != CH_LF) begin
      if (line_len < LINE_LIMIT - 1) begin
        store_line_byte(b);
        return;
      end
      // The byte that overflows the line is dropped.
      reply.command_code = CODE_OVERFLOW;
      reply.baud_value   = '0;
      reply.led_lit      = led_state;
      awaited_commands.push_back(reply);
      clear_line_state();
      return;
    end
    hit = CMD_NONE;
    for (int k = NUM_CMDS - 1; k >= 0; k--) begin
      if (still_matching[k] && line_len >= cmd_words[k].len()) hit = k;
    end
    reply.baud_value = '0;
    case (hit)
      CMD_HELP:     reply.command_code = CODE_HELP;
      CMD_LAMP_ON:  reply.command_code = CODE_LED_ON;
      CMD_LAMP_OFF: reply.command_code = CODE_LED_OFF;
      CMD_TOGGLE:   reply.command_code = CODE_TOGGLE;
      CMD_STATUS:   reply.command_code = CODE_STATUS;
      CMD_BAUD_QRY: begin
        reply.command_code = CODE_BAUD_QRY;
        reply.baud_value   = baud_reg;
      end
      CMD_BAUD_SET: begin
        if (num_neg && num_mag != 0) begin
          reply.command_code = CODE_BAUD_BAD;
        end else begin
          reply.baud_value   = num_mag;
          reply.command_code = (num_mag >= BAUD_LOW && num_mag <= BAUD_HIGH) ?
                               CODE_BAUD_OK : CODE_BAUD_BAD;
        end
      end
      default:      reply.command_code = CODE_UNKNOWN;
    endcase
    case (reply.command_code)
      CODE_LED_ON:  led_state = 1'b1;
      CODE_LED_OFF: led_state = 1'b0;
      CODE_TOGGLE:  led_state = ~led_state;
      default: ;
    endcase
    reply.led_lit = led_state;
    awaited_commands.push_back(reply);
    clear_line_state();
  endtask

  // Offers one byte, with random idle cycles ahead of it, and waits for the beat.
  task automatic feed_byte(input logic [7:0] b);
    bit skipped;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < feed_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    match_byte(b, skipped);
    if (!skipped) fed_count++;
  endtask

  task automatic feed_text(input string s);
    for (int i = 0; i < s.len(); i++) feed_byte(s[i]);
  endtask

  function automatic logic [7:0] noise_byte();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == CH_CR || v == CH_LF);
    return v;
  endfunction

  task automatic feed_terminator();
    case ($urandom_range(0, 2))
      0: feed_byte(CH_CR);
      1: feed_byte(CH_LF);
      default: begin
        feed_byte(CH_CR);
        feed_byte(CH_LF);
      end
    endcase
  endtask

  task automatic feed_baud_line();
    feed_text("BAUD=");
    repeat ($urandom_range(0, 2)) feed_byte(num_blanks[$urandom_range(0, 3)]);
    case ($urandom_range(0, 3))
      0: feed_byte(CH_PLUS);
      1: feed_byte(CH_MINUS);
      default: ;
    endcase
    case ($urandom_range(0, 6))
      0, 1: feed_text($sformatf("%0d", $urandom_range(BAUD_LOW, BAUD_HIGH)));
      2: begin
        feed_byte(CH_ZERO);
        feed_text($sformatf("%0d", $urandom_range(BAUD_LOW, BAUD_HIGH)));
      end
      3: feed_text($sformatf("%0d", $urandom_range(0, BAUD_LOW - 20'd1)));
      4: feed_text($sformatf("%0d", $urandom_range(BAUD_HIGH + 20'd1, BAUD_SAT)));
      5: begin
        // Long digit runs can drive the magnitude into saturation; else a baud limit or its neighbour is fed.
        if ($urandom_range(0, 1)) begin
          repeat ($urandom_range(7, 10)) feed_byte(8'(CH_ZERO + $urandom_range(0, 9)));
        end else begin
          feed_text($sformatf("%0d", baud_edges[$urandom_range(0, 3)]));
        end
      end
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) begin
      feed_byte(8'($urandom_range(32, 126)));
      repeat ($urandom_range(0, 2)) feed_byte(8'(CH_ZERO + $urandom_range(0, 9)));
    end
  endtask

  task automatic feed_random_line();
    int    kind;
    int    n;
    int    pos;
    string text;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) feed_byte(idle_skips[$urandom_range(0, 5)]);
    end
    if (kind < 45) begin
      text = cmd_words[$urandom_range(0, 5)];
      feed_text(text);
      repeat ($urandom_range(0, 3)) feed_byte(8'($urandom_range(32, 126)));
    end else if (kind < 62) begin
      feed_baud_line();
    end else if (kind < 76) begin
      text = cmd_words[$urandom_range(0, NUM_CMDS - 1)];
      n    = $urandom_range(1, text.len());
      pos  = $urandom_range(0, n - 1);
      for (int i = 0; i < n; i++) feed_byte((i == pos) ? noise_byte() : text[i]);
    end else if (kind < 92) begin
      repeat ($urandom_range(1, 20)) feed_byte(8'($urandom_range(0, 255)));
    end else begin
      // Around the line limit: exactly full, one over, or several over.
      feed_byte("A");
      repeat ($urandom_range(LINE_LIMIT - 2, LINE_LIMIT + 4)) feed_byte(noise_byte());
    end
    feed_terminator();
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (awaited_commands.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_baud(input logic [19:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    baud_reg = value;
  endtask

  task automatic test_directed_lines();
    feed_text(" #/\t\r\n");
    feed_text("BAUD?\r");
    feed_text("BAUD=-7\n");
    feed_byte(8'h00);
    feed_byte(8'hFF);
    feed_byte(CH_CR);
  endtask

  task automatic test_random_lines(input int budget);
    int start;
    start = fed_count;
    while (fed_count - start < budget) feed_random_line();
  endtask

  // The sink holds off while lines keep coming, so both result slots fill and input stalls.
  task automatic test_output_stall();
    sink_hold_left = STALL_SPAN;
    repeat (12) feed_random_line();
    drain_results();
    repeat (6) feed_random_line();
  endtask

  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_left > 0) begin
        m_axis_tready_i <= 1'b0;
        sink_hold_left--;
      end else begin
        m_axis_tready_i <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    ucl_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (awaited_commands.size() == 0) begin
        report_mismatch("unexpected result beat", m_axis_tdata_o, 0);
      end else begin
        want = awaited_commands.pop_front();
        if (m_axis_tdata_o[3:0] !== want.command_code)
          report_mismatch("command_code", m_axis_tdata_o[3:0], want.command_code);
        if (m_axis_tdata_o[23:4] !== want.baud_value)
          report_mismatch("baud_value", m_axis_tdata_o[23:4], want.baud_value);
        if (m_axis_tdata_o[24] !== want.led_lit)
          report_mismatch("led_lit", m_axis_tdata_o[24], want.led_lit);
        if (m_axis_tdata_o[31:25] !== 7'd0)
          report_mismatch("tdata padding", m_axis_tdata_o[31:25], 0);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    mismatch_count  = 0;
    fed_count       = 0;
    sink_hold_left  = 0;
    feed_idle_pct   = 24;
    sink_idle_pct   = 86;
    led_state       = 1'b0;
    baud_reg        = BAUD_RESET;
    clear_line_state();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_lines();
    set_baud(BAUD_LOW);
    test_random_lines(120);

    feed_idle_pct = 86;
    sink_idle_pct = 24;
    set_baud(BAUD_HIGH);
    test_random_lines(120);

    feed_idle_pct = 0;
    sink_idle_pct = 0;
    test_output_stall();
    set_baud(20'($urandom_range(BAUD_LOW, BAUD_HIGH)));
    test_random_lines(120);

    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/ucl_pkg.sv
hdl/ucl_line_parser.sv
hdl/ucl_out_buf.sv
hdl/uart_command_line_matcher_core.sv
test/tb.sv
